### rtl/vdi_pkg.sv
// Shared constants and types for the vertex dedup indexer.
`default_nettype none
package vdi_pkg;
    localparam int TABLE_DEPTH = 4096;
    localparam int F_W         = 32;
    localparam int KEY_W       = 8 * F_W;
    localparam int IDX_OUT_W   = 12;
    localparam int NCELL       = 8;
    localparam int CELL_W      = $clog2(NCELL);
    localparam int ROWS        = (TABLE_DEPTH + NCELL - 1) / NCELL;
    localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ENT_W       = ROW_W + CELL_W;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W       = (ENT_W > CNT_W) ? ENT_W : CNT_W;

    typedef logic [KEY_W-1:0] t_key;

    // search word walking down the cell chain
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [ROW_W-1:0] row;
        logic             hit;
        logic [ENT_W-1:0] idx;
    } t_tok;

    // store command broadcast to all cells
    typedef struct packed {
        logic              en;
        logic [CELL_W-1:0] bank;
        logic [ROW_W-1:0]  row;
    } t_wr;
endpackage
`default_nettype wire

### rtl/vdi_in_if.sv
// Input channel: one vertex word per handshake.
`default_nettype none
interface vdi_in_if;
    logic        valid;
    logic        ready;
    logic        mesh_start;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] nrm_x;
    logic [31:0] nrm_y;
    logic [31:0] nrm_z;
    logic        has_uv;
    logic [31:0] tex_u;
    logic [31:0] tex_v;

    modport source (output valid, mesh_start, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z,
                     has_uv, tex_u, tex_v, input ready);
    modport sink   (input valid, mesh_start, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z,
                    has_uv, tex_u, tex_v, output ready);
endinterface
`default_nettype wire

### rtl/vdi_out_if.sv
// Output channel: one index result word per handshake.
`default_nettype none
interface vdi_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] vertex_index;
    logic        is_new;
    logic        table_full;
    logic        uv_written;
    logic [31:0] out_pos_x;
    logic [31:0] out_pos_y;
    logic [31:0] out_pos_z;
    logic [31:0] out_nrm_x;
    logic [31:0] out_nrm_y;
    logic [31:0] out_nrm_z;
    logic [31:0] out_tex_u;
    logic [31:0] out_tex_v;

    modport source (output valid, vertex_index, is_new, table_full, uv_written,
                     out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y, out_nrm_z,
                     out_tex_u, out_tex_v, input ready);
    modport sink   (input valid, vertex_index, is_new, table_full, uv_written,
                    out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y, out_nrm_z,
                    out_tex_u, out_tex_v, output ready);
endinterface
`default_nettype wire

### rtl/vdi_cell.sv
// One search cell: a bank of stored keys, compare stage, and chain registers.
`default_nettype none
module vdi_cell (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [vdi_pkg::CELL_W-1:0] i_cell_id,
    input  wire vdi_pkg::t_key         i_key,
    input  wire logic [vdi_pkg::CNT_W-1:0]  i_count,
    input  wire vdi_pkg::t_wr          i_wr,
    input  wire vdi_pkg::t_tok         i_tok,
    output vdi_pkg::t_tok              o_tok
);
    import vdi_pkg::*;

    t_key             mem [ROWS];
    t_key             r_rd;
    t_tok             r_a;
    t_tok             r_b;
    logic [ENT_W-1:0] entry;
    logic             match;

    // bank: entry e lives in cell e % NCELL, row e / NCELL
    always_ff @(posedge i_clk) begin
        if (i_wr.en && i_wr.bank == i_cell_id) begin
            mem[i_wr.row] <= i_key;
        end
        if (i_tok.valid) begin
            r_rd <= mem[i_tok.row];
        end
    end

    assign entry = {r_a.row, i_cell_id};
    assign match = r_a.valid && (CMP_W'(entry) < CMP_W'(i_count)) && (r_rd == i_key);

    always_ff @(posedge i_clk) begin
        r_a.last <= i_tok.last;
        r_a.row  <= i_tok.row;
        r_a.hit  <= i_tok.hit;
        r_a.idx  <= i_tok.idx;
        r_b.last <= r_a.last;
        r_b.row  <= r_a.row;
        r_b.hit  <= r_a.hit | match;
        r_b.idx  <= match ? entry : r_a.idx;
        if (!i_rst_n) begin
            r_a.valid <= 1'b0;
            r_b.valid <= 1'b0;
        end else begin
            r_a.valid <= i_tok.valid;
            r_b.valid <= r_a.valid;
        end
    end

    assign o_tok = r_b;
endmodule
`default_nettype wire

### rtl/vertex_dedup_indexer.sv
// Top level: vertex dedup indexer built from a chain of search cells.
//
// i_in carries one vertex word (position, normal, optional UV, mesh start).
// o_out returns one result word per vertex: the unique-vertex index, the
// new/full/UV flags and, for a new vertex, the vertex echoed back.
// Stored vertices are spread over 8 cells, one bank row per 8 entries. A
// lookup streams the occupied rows into the chain, one row per cycle; each
// cell compares its entry against the held key and passes the word on.
// After a vertex is accepted, the lookup runs the row sweep over the
// stored vertices, passes two register stages per cell, then issues the
// result and stores a new vertex. With an empty store (after reset or
// mesh_start) the sweep and the chain are skipped and the result is
// issued directly. The next vertex is taken once the result is issued and
// the state is back to idle; one vertex is in work at a time.
// i_in.ready is high only while no lookup runs; a finished result waits in
// the output register, so a new vertex is taken while the receiver stalls,
// and the next result waits until that register is free.
// Reset empties the store (count of unique vertices goes to zero); no
// clearing pass is needed. A vertex with mesh_start set empties it too.
// Once the store is full, new vertices are reported with table_full set.
`default_nettype none
module vertex_dedup_indexer (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    vdi_in_if.sink    i_in,
    vdi_out_if.source o_out
);
    import vdi_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_FIN   = 4'b1000
    } t_state;

    t_state                r_state;
    t_key                  r_key;
    logic                  r_uv;
    logic [CNT_W-1:0]      r_count;
    logic [ROW_W-1:0]      r_row;
    logic [ROW_W-1:0]      r_row_last;
    logic                  r_hit;
    logic [ENT_W-1:0]      r_idx;
    logic                  r_ovalid;
    logic [IDX_OUT_W-1:0]  r_o_idx;
    logic                  r_o_new;
    logic                  r_o_full;
    logic                  r_o_uv;
    t_key                  r_o_key;

    t_tok                  w_tok [NCELL+1];
    t_wr                   w_wr;
    t_key                  n_key;
    logic [CNT_W-1:0]      n_count;
    logic                  in_go;
    logic                  fin_go;
    logic                  room;

    assign in_go   = i_in.valid && i_in.ready;
    assign fin_go  = (r_state == S_FIN) && (!r_ovalid || o_out.ready);
    assign room    = r_count < CNT_W'(TABLE_DEPTH);
    assign n_count = i_in.mesh_start ? '0 : r_count;
    assign n_key   = {i_in.pos_x, i_in.pos_y, i_in.pos_z,
                      i_in.nrm_x, i_in.nrm_y, i_in.nrm_z,
                      i_in.has_uv ? i_in.tex_u : 32'd0,
                      i_in.has_uv ? i_in.tex_v : 32'd0};

    assign i_in.ready = (r_state == S_IDLE);

    assign w_tok[0].valid = (r_state == S_SCAN);
    assign w_tok[0].last  = (r_row == r_row_last);
    assign w_tok[0].row   = r_row;
    assign w_tok[0].hit   = 1'b0;
    assign w_tok[0].idx   = '0;

    assign w_wr.en   = fin_go && !r_hit && room;
    assign w_wr.bank = r_count[CELL_W-1:0];
    assign w_wr.row  = ROW_W'(r_count >> CELL_W);

    for (genvar c = 0; c < NCELL; c++) begin : g_cell
        vdi_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cell_id (CELL_W'(c)),
            .i_key     (r_key),
            .i_count   (r_count),
            .i_wr      (w_wr),
            .i_tok     (w_tok[c]),
            .o_tok     (w_tok[c+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (fin_go) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_go) begin
                        r_count <= n_count;
                        r_state <= (n_count == '0) ? S_FIN : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_row == r_row_last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (w_tok[NCELL].valid && w_tok[NCELL].last) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (fin_go) begin
                        if (w_wr.en) begin
                            r_count <= r_count + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_go) begin
            r_key      <= n_key;
            r_uv       <= i_in.has_uv;
            r_row      <= '0;
            r_row_last <= ROW_W'((n_count - 1'b1) >> CELL_W);
            r_hit      <= 1'b0;
        end else begin
            if (r_state == S_SCAN) begin
                r_row <= r_row + 1'b1;
            end
            if (w_tok[NCELL].valid && w_tok[NCELL].hit) begin
                r_hit <= 1'b1;
                r_idx <= w_tok[NCELL].idx;
            end
        end
        if (fin_go) begin
            if (r_hit) begin
                r_o_idx  <= IDX_OUT_W'(r_idx);
                r_o_new  <= 1'b0;
                r_o_full <= 1'b0;
                r_o_uv   <= 1'b0;
                r_o_key  <= '0;
            end else begin
                r_o_idx  <= room ? IDX_OUT_W'(r_count) : '0;
                r_o_new  <= 1'b1;
                r_o_full <= !room;
                r_o_uv   <= r_uv;
                r_o_key  <= r_key;
            end
        end
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.vertex_index = r_o_idx;
    assign o_out.is_new       = r_o_new;
    assign o_out.table_full   = r_o_full;
    assign o_out.uv_written   = r_o_uv;
    assign o_out.out_pos_x    = r_o_key[8*F_W-1:7*F_W];
    assign o_out.out_pos_y    = r_o_key[7*F_W-1:6*F_W];
    assign o_out.out_pos_z    = r_o_key[6*F_W-1:5*F_W];
    assign o_out.out_nrm_x    = r_o_key[5*F_W-1:4*F_W];
    assign o_out.out_nrm_y    = r_o_key[4*F_W-1:3*F_W];
    assign o_out.out_nrm_z    = r_o_key[3*F_W-1:2*F_W];
    assign o_out.out_tex_u    = r_o_key[2*F_W-1:F_W];
    assign o_out.out_tex_v    = r_o_key[F_W-1:0];
endmodule
`default_nettype wire
